### rtl/core/dmpid_pkg.sv
// Shared types, widths, register indexes and reset values for the
// dual-motor PID speed controller. No dependencies.
`timescale 1ns / 1ps

package dmpid_pkg;

    // Field widths
    localparam int POS_W      = 32;
    localparam int SPD_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int ILIM_W     = 20;
    localparam int DIR_W      = 2;
    localparam int DUTY_W     = 8;
    localparam int ERR_W      = 18;   // target - speed
    localparam int DERR_W     = 19;   // e - last_error
    localparam int ESUM_W     = 21;   // clamped error sum
    localparam int SUM_W      = 40;   // PID sum before clamping

    // Stream and config port widths
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // Speed window in control ticks
    localparam int SPEED_WINDOW = 10;
    localparam int WT_W         = 4;

    // Duty divider: one quotient bit per cycle
    localparam int DIV_STEPS  = 8;
    localparam int DCNT_W     = 3;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4,
        REG_RPM_PER_COUNT  = 3'd5,
        REG_DIRECTION_A    = 3'd6,
        REG_DIRECTION_B    = 3'd7
    } reg_idx_t;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

    // Register reset values
    localparam logic [GAIN_W-1:0] RST_GAIN_P         = 16'd3891;
    localparam logic [GAIN_W-1:0] RST_GAIN_I         = 16'd410;
    localparam logic [GAIN_W-1:0] RST_GAIN_D         = 16'd1;
    localparam logic [ILIM_W-1:0] RST_INTEGRAL_LIMIT = 20'd1024000;
    localparam logic [SPD_W-1:0]  RST_OUTPUT_LIMIT   = 16'd42598;
    localparam logic [SPD_W-1:0]  RST_RPM_PER_COUNT  = 16'd10486;
    localparam logic [DIR_W-1:0]  RST_DIRECTION      = DIR_REV;

    // Configuration register file
    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [ILIM_W-1:0] integral_limit;
        logic [SPD_W-1:0]  output_limit;
        logic [SPD_W-1:0]  rpm_per_count;
        logic [DIR_W-1:0]  direction_a;
        logic [DIR_W-1:0]  direction_b;
    } cfg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG,
        ST_SPEED,
        ST_ERR,
        ST_PROD,
        ST_SUM,
        ST_DINIT,
        ST_DIV,
        ST_DONE
    } state_t;

    // Step strobes from the sequencer to each lane
    typedef struct packed {
        logic load_in;
        logic win;
        logic mag_en;
        logic speed_en;
        logic err_en;
        logic prod_en;
        logic sum_en;
        logic dinit;
        logic dstep;
    } lane_ctl_t;

endpackage

### rtl/core/dmpid_lane.sv
// One motor lane: windowed encoder speed, PID in Q8.8 with Q4.12 gains,
// and a bit-serial duty divider. Depends on dmpid_pkg.
`timescale 1ns / 1ps

module dmpid_lane
    import dmpid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  lane_ctl_t         ctl,
    input  logic [POS_W-1:0]  position,
    input  logic [SPD_W-1:0]  target,
    output logic [DUTY_W-1:0] duty,
    output logic [SPD_W-1:0]  speed
);

    // Captured word and pipeline registers
    logic [POS_W-1:0]          pos_reg;
    logic [SPD_W-1:0]          tgt_reg;
    logic [POS_W-1:0]          mag_reg;
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [DERR_W-1:0]  de_reg;
    logic signed [34:0]        prod_p_reg;
    logic signed [37:0]        prod_i_reg;
    logic signed [35:0]        prod_d_reg;
    logic [DUTY_W-1:0]         q_reg;
    logic [DUTY_W-1:0]         rem_reg;
    logic [DUTY_W-1:0]         quo_reg;

    // Controller state
    logic [POS_W-1:0]          prev_reg;
    logic [SPD_W-1:0]          speed_reg;
    logic signed [ESUM_W-1:0]  esum_reg;
    logic signed [ERR_W-1:0]   last_reg;

    // Combinational intermediates
    logic [POS_W-1:0]          delta;
    logic [POS_W-1:0]          mag_next;
    logic [47:0]               rpm_prod;
    logic [SPD_W-1:0]          speed_next;
    logic signed [ERR_W-1:0]   e_next;
    logic signed [DERR_W-1:0]  de_next;
    logic signed [ESUM_W:0]    esum_sum;
    logic signed [ESUM_W:0]    ilim;
    logic signed [ESUM_W:0]    esum_clamp;
    logic signed [22:0]        term_p;
    logic signed [25:0]        term_i;
    logic signed [23:0]        term_d;
    logic signed [SUM_W-1:0]   pid_sum;
    logic [SPD_W-1:0]          out_clamp;
    logic [SPD_W-1:0]          num;
    logic [DUTY_W:0]           rem_wide;
    logic                      rem_ge;
    logic [DUTY_W-1:0]         full;

    // Absolute position delta over the window
    always_comb
    begin
        delta    = pos_reg - prev_reg;
        mag_next = delta[POS_W-1] ? (~delta + 32'd1) : delta;
    end

    // Scale to rpm Q8.8, saturate at the top
    always_comb
    begin
        rpm_prod   = mag_reg * cfg.rpm_per_count;
        speed_next = (|rpm_prod[47:24]) ? {SPD_W{1'b1}} : rpm_prod[23:8];
    end

    // Error and error difference
    always_comb
    begin
        e_next  = $signed({2'b00, tgt_reg}) - $signed({2'b00, speed_reg});
        de_next = $signed({e_next[ERR_W-1], e_next}) - $signed({last_reg[ERR_W-1], last_reg});
    end

    // Clamp the updated error sum
    always_comb
    begin
        esum_sum = 22'(esum_reg) + 22'(e_reg);
        ilim     = $signed({2'b00, cfg.integral_limit});
        if (esum_sum > ilim)
        begin
            esum_clamp = ilim;
        end
        else if (esum_sum < -ilim)
        begin
            esum_clamp = -ilim;
        end
        else
        begin
            esum_clamp = esum_sum;
        end
    end

    // Floor each product by 4096, add, clamp to 0..output_limit
    always_comb
    begin
        term_p  = prod_p_reg[34:12];
        term_i  = prod_i_reg[37:12];
        term_d  = prod_d_reg[35:12];
        pid_sum = SUM_W'(term_p) + SUM_W'(term_i) + SUM_W'(term_d);
        if (pid_sum < 0)
        begin
            out_clamp = '0;
        end
        else if (pid_sum > $signed({24'd0, cfg.output_limit}))
        begin
            out_clamp = cfg.output_limit;
        end
        else
        begin
            out_clamp = pid_sum[SPD_W-1:0];
        end
    end

    // Restoring division step: q*255 / floor(limit/256)
    always_comb
    begin
        full     = cfg.output_limit[SPD_W-1:8];
        num      = {q_reg, 8'd0} - {8'd0, q_reg};
        rem_wide = {rem_reg, quo_reg[DUTY_W-1]};
        rem_ge   = (rem_wide >= {1'b0, full});
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            pos_reg <= position;
            tgt_reg <= target;
        end
        if (ctl.mag_en)
        begin
            mag_reg <= mag_next;
        end
        if (ctl.err_en)
        begin
            e_reg  <= e_next;
            de_reg <= de_next;
        end
        if (ctl.prod_en)
        begin
            prod_p_reg <= $signed({1'b0, cfg.gain_p}) * e_reg;
            prod_i_reg <= $signed({1'b0, cfg.gain_i}) * esum_reg;
            prod_d_reg <= $signed({1'b0, cfg.gain_d}) * de_reg;
        end
        if (ctl.sum_en)
        begin
            q_reg <= out_clamp[SPD_W-1:8];
        end
        if (ctl.dinit)
        begin
            rem_reg <= num[SPD_W-1:8];
            quo_reg <= num[7:0];
        end
        else if (ctl.dstep)
        begin
            rem_reg <= rem_ge ? DUTY_W'(rem_wide - {1'b0, full}) : rem_wide[DUTY_W-1:0];
            quo_reg <= {quo_reg[DUTY_W-2:0], rem_ge};
        end
    end

    // Controller state: speed on window ticks, sums on every tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            speed_reg <= '0;
            esum_reg  <= '0;
            last_reg  <= '0;
        end
        else
        begin
            if (ctl.mag_en && ctl.win)
            begin
                prev_reg <= pos_reg;
            end
            if (ctl.speed_en && ctl.win)
            begin
                speed_reg <= speed_next;
            end
            if (ctl.prod_en)
            begin
                esum_reg <= esum_clamp[ESUM_W-1:0];
                last_reg <= e_reg;
            end
        end
    end

    assign duty  = (full == '0) ? '0 : quo_reg;
    assign speed = speed_reg;

endmodule

### rtl/core/dmpid_merge.sv
// Merge stage: routes each lane's duty to its forward or reverse pin and
// holds the finished result word for the master side. Depends on dmpid_pkg.
`timescale 1ns / 1ps

module dmpid_merge
    import dmpid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [DUTY_W-1:0]     duty_a,
    input  logic [DUTY_W-1:0]     duty_b,
    input  logic [SPD_W-1:0]      speed_a,
    input  logic [SPD_W-1:0]      speed_b,
    input  logic [DIR_W-1:0]      direction_a,
    input  logic [DIR_W-1:0]      direction_b,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [OUT_DATA_W-1:0] data_reg;
    logic                  valid_reg;
    logic                  valid_next;
    logic [DUTY_W-1:0]     fwd_a;
    logic [DUTY_W-1:0]     rev_a;
    logic [DUTY_W-1:0]     fwd_b;
    logic [DUTY_W-1:0]     rev_b;

    // Route duties by direction; stop and unused codes drive both pins low
    always_comb
    begin
        fwd_a = (direction_a == DIR_FWD) ? duty_a : '0;
        rev_a = (direction_a == DIR_REV) ? duty_a : '0;
        fwd_b = (direction_b == DIR_FWD) ? duty_b : '0;
        rev_b = (direction_b == DIR_REV) ? duty_b : '0;
    end

    // Hold the word until taken; a new load wins
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {speed_b, speed_a, rev_b, fwd_b, rev_a, fwd_a};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

### rtl/core/dual_motor_pid_speed_control.sv
// Top level of the dual-motor PID speed controller: config registers,
// tick sequencer, two motor lanes and the merge stage. Depends on dmpid_pkg,
// dmpid_lane and dmpid_merge.
`timescale 1ns / 1ps

// Each input word is one control tick for two motors. Both motors run in
// parallel lanes. A tick is accepted, then goes through the arithmetic chain
// (position delta, rpm scaling, error, the three gain products, PID sum and
// clamp, duty numerator) and the bit-serial duty divider, which yields one
// quotient bit per cycle; its result then moves into the output register
// once that is free or being drained. The next tick is accepted while a
// finished result still waits on the master side. Speed is refreshed every
// 10th tick and held in between. Config registers may be written only while
// no tick is in flight.
module dual_motor_pid_speed_control
    import dmpid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Config write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // position_a, position_b, target_a, target_b
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // fwd_duty_a, rev_duty_a, fwd_duty_b,
                                            // rev_duty_b, speed_a, speed_b
);

    cfg_t              cfg_reg;
    state_t            state_reg;
    state_t            state_next;
    logic [WT_W-1:0]   wt_reg;
    logic [WT_W-1:0]   wt_inc;
    logic              win_reg;
    logic              win_next;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              accept;
    logic              load_out;
    lane_ctl_t         ctl;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [SPD_W-1:0]  speed_a;
    logic [SPD_W-1:0]  speed_b;

    // Config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= RST_GAIN_P;
            cfg_reg.gain_i         <= RST_GAIN_I;
            cfg_reg.gain_d         <= RST_GAIN_D;
            cfg_reg.integral_limit <= RST_INTEGRAL_LIMIT;
            cfg_reg.output_limit   <= RST_OUTPUT_LIMIT;
            cfg_reg.rpm_per_count  <= RST_RPM_PER_COUNT;
            cfg_reg.direction_a    <= RST_DIRECTION;
            cfg_reg.direction_b    <= RST_DIRECTION;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_GAIN_P:         cfg_reg.gain_p         <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:         cfg_reg.gain_i         <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:         cfg_reg.gain_d         <= cfg_wdata[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_wdata[ILIM_W-1:0];
                REG_OUTPUT_LIMIT:   cfg_reg.output_limit   <= cfg_wdata[SPD_W-1:0];
                REG_RPM_PER_COUNT:  cfg_reg.rpm_per_count  <= cfg_wdata[SPD_W-1:0];
                REG_DIRECTION_A:    cfg_reg.direction_a    <= cfg_wdata[DIR_W-1:0];
                REG_DIRECTION_B:    cfg_reg.direction_b    <= cfg_wdata[DIR_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    // Window tick counter: wrap and flag a speed update
    always_comb
    begin
        wt_inc   = wt_reg + WT_W'(1);
        win_next = (wt_inc >= WT_W'(SPEED_WINDOW));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_reg  <= '0;
            win_reg <= 1'b0;
        end
        else if (accept)
        begin
            wt_reg  <= win_next ? '0 : wt_inc;
            win_reg <= win_next;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = s_tvalid ? ST_MAG : ST_IDLE;
            ST_MAG:   state_next = ST_SPEED;
            ST_SPEED: state_next = ST_ERR;
            ST_ERR:   state_next = ST_PROD;
            ST_PROD:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_DINIT;
            ST_DINIT: state_next = ST_DIV;
            ST_DIV:   state_next = (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) ? ST_DONE : ST_DIV;
            ST_DONE:  state_next = (!m_tvalid || m_tready) ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        ctl          = '0;
        ctl.win      = win_reg;
        s_tready     = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                ctl.load_in = s_tvalid;
            end
            ST_MAG:   ctl.mag_en   = 1'b1;
            ST_SPEED: ctl.speed_en = 1'b1;
            ST_ERR:   ctl.err_en   = 1'b1;
            ST_PROD:  ctl.prod_en  = 1'b1;
            ST_SUM:   ctl.sum_en   = 1'b1;
            ST_DINIT: ctl.dinit    = 1'b1;
            ST_DIV:   ctl.dstep    = 1'b1;
            ST_DONE:  load_out     = !m_tvalid || m_tready;
            default:  ctl          = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= (state_reg == ST_DIV) ? dcnt_reg + DCNT_W'(1) : '0;
        end
    end

    // Motor lanes
    dmpid_lane u_lane_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .ctl      (ctl),
        .position (s_tdata[31:0]),
        .target   (s_tdata[79:64]),
        .duty     (duty_a),
        .speed    (speed_a)
    );

    dmpid_lane u_lane_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .ctl      (ctl),
        .position (s_tdata[63:32]),
        .target   (s_tdata[95:80]),
        .duty     (duty_b),
        .speed    (speed_b)
    );

    // Pin routing and output register
    dmpid_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load_out),
        .duty_a      (duty_a),
        .duty_b      (duty_b),
        .speed_a     (speed_a),
        .speed_b     (speed_b),
        .direction_a (cfg_reg.direction_a),
        .direction_b (cfg_reg.direction_b),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

`ifndef SYNTHESIS
    // One tick in flight: no second word right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input accepted while a tick is in flight");

    // A result is loaded only into a free or draining output register
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!m_tvalid || m_tready))
        else $error("output register overwritten before it was taken");

    // A new result appears only after the sequencer finished a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result shown without a finished tick");
`endif

endmodule
